>>> rtl/rgb_to_hsv_converter_macros.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_macros
// assertion shorthands used by the rgb to hsv converter top
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc assertion failed");

// next-cycle implication, checked out of reset
`define RHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc assertion failed");

`endif

>>> rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// types, constants and the divider step shared by the rgb to hsv converter
// ----------------------------------------------------------------------------
package rhc_pkg;

  // channel and hue formats
  localparam int CH_W      = 8;
  localparam int HUE_FRAC  = 6;
  localparam int HUE_W     = 15;
  // quotient bits of 60 degrees times 2^HUE_FRAC (at most 3840)
  localparam int QUO_W     = 12;
  localparam int DVD_W     = CH_W + QUO_W;
  localparam int SAT_PAD   = QUO_W - CH_W;
  localparam int NUM_CELLS = QUO_W;

  localparam logic [QUO_W-1:0] DEG60  = QUO_W'(60 << HUE_FRAC);
  localparam logic [HUE_W:0]   DEG360 = (HUE_W+1)'(360 << HUE_FRAC);
  localparam logic [CH_W-1:0]  CH_MAX = {CH_W{1'b1}};

  // dominant channel codes
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic             hue_undefined;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  value;
    logic [CH_W-1:0]  alpha_out;
  } result_t;

  // one divider lane: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [CH_W-1:0]  rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // everything a cell of the chain carries
  typedef struct packed {
    div_lane_t       hue_lane;
    div_lane_t       sat_lane;
    logic [CH_W-1:0] delta;
    logic [CH_W-1:0] value;
    logic [1:0]      sector;
    logic            neg;
    logic [CH_W-1:0] alpha;
  } cell_t;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t lane, logic [CH_W-1:0] divisor);
    logic [CH_W:0] trial;
    div_lane_t     res;
    trial = {lane.rem, lane.quo[QUO_W-1]};
    if (trial >= {1'b0, divisor}) begin
      res.rem = CH_W'(trial - {1'b0, divisor});
      res.quo = {lane.quo[QUO_W-2:0], 1'b1};
    end else begin
      res.rem = trial[CH_W-1:0];
      res.quo = {lane.quo[QUO_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

>>> rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// max/min search, sector pick and divider operand setup over two stages
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rhc_pkg::pixel_in_t in_pixel,
  output logic               out_valid,
  output rhc_pkg::cell_t     out_cell
);

  // stage a registers
  logic                     a_valid_r, a_valid_nxt;
  rhc_pkg::pixel_in_t       a_pix_r;
  logic [rhc_pkg::CH_W-1:0] a_max_r, a_max_nxt;
  logic [rhc_pkg::CH_W-1:0] a_min_r, a_min_nxt;
  logic [1:0]               a_sect_r, a_sect_nxt;

  // stage b registers
  logic                     b_valid_r;
  rhc_pkg::cell_t           b_cell_r, b_cell_nxt;

  logic [rhc_pkg::CH_W-1:0]  delta;
  logic signed [rhc_pkg::CH_W:0] diff;
  logic [rhc_pkg::CH_W-1:0]  mag;
  logic [rhc_pkg::DVD_W-1:0] hue_dvd;
  logic [rhc_pkg::DVD_W-1:0] sat_dvd;

  // dominant channel, red wins ties, then green
  always_comb begin
    a_valid_nxt = in_valid;
    if (in_pixel.red >= in_pixel.green && in_pixel.red >= in_pixel.blue) begin
      a_sect_nxt = rhc_pkg::SECT_RED;
      a_max_nxt  = in_pixel.red;
    end else if (in_pixel.green >= in_pixel.blue) begin
      a_sect_nxt = rhc_pkg::SECT_GREEN;
      a_max_nxt  = in_pixel.green;
    end else begin
      a_sect_nxt = rhc_pkg::SECT_BLUE;
      a_max_nxt  = in_pixel.blue;
    end
    a_min_nxt = in_pixel.red;
    if (in_pixel.green < a_min_nxt) a_min_nxt = in_pixel.green;
    if (in_pixel.blue < a_min_nxt) a_min_nxt = in_pixel.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
    a_pix_r  <= in_pixel;
    a_max_r  <= a_max_nxt;
    a_min_r  <= a_min_nxt;
    a_sect_r <= a_sect_nxt;
  end

  // channel difference of the sector
  always_comb begin
    delta = a_max_r - a_min_r;
    unique case (a_sect_r)
      rhc_pkg::SECT_RED:   diff = $signed({1'b0, a_pix_r.green}) - $signed({1'b0, a_pix_r.blue});
      rhc_pkg::SECT_GREEN: diff = $signed({1'b0, a_pix_r.blue}) - $signed({1'b0, a_pix_r.red});
      default:             diff = $signed({1'b0, a_pix_r.red}) - $signed({1'b0, a_pix_r.green});
    endcase
    mag = diff[rhc_pkg::CH_W] ? rhc_pkg::CH_W'(-diff) : diff[rhc_pkg::CH_W-1:0];
  end

  // dividends: 60deg * |diff| and delta * full scale, padded to the quotient width
  always_comb begin
    hue_dvd = rhc_pkg::DVD_W'(mag) * rhc_pkg::DVD_W'(rhc_pkg::DEG60);
    sat_dvd = (rhc_pkg::DVD_W'(delta) * rhc_pkg::DVD_W'(rhc_pkg::CH_MAX)) << rhc_pkg::SAT_PAD;
    b_cell_nxt.hue_lane.rem = hue_dvd[rhc_pkg::DVD_W-1 -: rhc_pkg::CH_W];
    b_cell_nxt.hue_lane.quo = hue_dvd[rhc_pkg::QUO_W-1:0];
    b_cell_nxt.sat_lane.rem = sat_dvd[rhc_pkg::DVD_W-1 -: rhc_pkg::CH_W];
    b_cell_nxt.sat_lane.quo = sat_dvd[rhc_pkg::QUO_W-1:0];
    b_cell_nxt.delta        = delta;
    b_cell_nxt.value        = a_max_r;
    b_cell_nxt.sector       = a_sect_r;
    b_cell_nxt.neg          = diff[rhc_pkg::CH_W];
    b_cell_nxt.alpha        = a_pix_r.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_cell_r <= b_cell_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_cell  = b_cell_r;

endmodule

>>> rtl/rhc_div_cell.sv
// ----------------------------------------------------------------------------
// rhc_div_cell
// one link of the divider chain: one quotient bit for hue and saturation
// ----------------------------------------------------------------------------
module rhc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rhc_pkg::cell_t in_cell,
  output logic           out_valid,
  output rhc_pkg::cell_t out_cell
);

  logic           valid_r;
  rhc_pkg::cell_t cell_r, cell_nxt;

  // hue divides by delta, saturation by the max channel
  always_comb begin
    cell_nxt          = in_cell;
    cell_nxt.hue_lane = rhc_pkg::div_step(in_cell.hue_lane, in_cell.delta);
    cell_nxt.sat_lane = rhc_pkg::div_step(in_cell.sat_lane, in_cell.value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    cell_r <= cell_nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

>>> rtl/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// hue assembly from sector and quotient, black and grey handling
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  rhc_pkg::cell_t   in_cell,
  output logic             out_valid,
  output rhc_pkg::result_t out_result
);

  logic                      valid_r;
  rhc_pkg::result_t          res_r, res_nxt;
  logic [rhc_pkg::HUE_W:0]   base;
  logic [rhc_pkg::HUE_W:0]   quo;
  logic [rhc_pkg::HUE_W:0]   hue_raw;
  logic                      black;
  logic                      grey;

  // sector offset plus or minus the quotient, wrapped into 0..360
  always_comb begin
    unique case (in_cell.sector)
      rhc_pkg::SECT_RED:   base = '0;
      rhc_pkg::SECT_GREEN: base = (rhc_pkg::HUE_W+1)'(2) * (rhc_pkg::HUE_W+1)'(rhc_pkg::DEG60);
      default:             base = (rhc_pkg::HUE_W+1)'(4) * (rhc_pkg::HUE_W+1)'(rhc_pkg::DEG60);
    endcase
    quo     = (rhc_pkg::HUE_W+1)'(in_cell.hue_lane.quo);
    hue_raw = in_cell.neg ? base - quo : base + quo;
    if (hue_raw[rhc_pkg::HUE_W]) hue_raw = hue_raw + rhc_pkg::DEG360;
  end

  // black and grey force hue and saturation to zero
  always_comb begin
    black                 = (in_cell.value == '0);
    grey                  = (in_cell.delta == '0);
    res_nxt.hue           = grey ? '0 : hue_raw[rhc_pkg::HUE_W-1:0];
    res_nxt.hue_undefined = black;
    res_nxt.saturation    = grey ? '0
                          : in_cell.sat_lane.quo[rhc_pkg::QUO_W-1 -: rhc_pkg::CH_W];
    res_nxt.value         = in_cell.value;
    res_nxt.alpha_out     = in_cell.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    res_r <= res_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

>>> rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// hexcone rgb to hsv conversion, one pixel per clock
// ----------------------------------------------------------------------------
// Takes one pixel per clock (busy is never raised) and returns its hsv result
// on out_result, flagged by a one-cycle out_valid strobe; the receiver must
// take it then. The result passes through two operand stages, a chain of
// 12 divider cells (one quotient bit each, hue and saturation side by side)
// and one output stage. Hue is degrees times 64, saturation is
// delta*255/max truncated, value is the max channel; a black pixel sets
// hue_undefined with hue and saturation zero, a grey pixel gives hue zero.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rhc_pkg::pixel_in_t in_pixel,
  output logic               out_valid,
  output rhc_pkg::result_t   out_result
);

  logic           chain_valid [0:rhc_pkg::NUM_CELLS];
  rhc_pkg::cell_t chain_cell  [0:rhc_pkg::NUM_CELLS];
  logic           in_req;

  // fully pipelined, every request is taken
  assign busy   = 1'b0;
  assign in_req = start && !busy;

  // operand setup
  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req),
    .in_pixel  (in_pixel),
    .out_valid (chain_valid[0]),
    .out_cell  (chain_cell[0])
  );

  // divider chain
  for (genvar i = 0; i < rhc_pkg::NUM_CELLS; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_cell   (chain_cell[i]),
      .out_valid (chain_valid[i+1]),
      .out_cell  (chain_cell[i+1])
    );
  end

  // hue assembly and output register
  rhc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chain_valid[rhc_pkg::NUM_CELLS]),
    .in_cell    (chain_cell[rhc_pkg::NUM_CELLS]),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // black pixels give all-zero hsv
  `RHC_ASSERT_IMPL(a_black_zero, out_valid && out_result.hue_undefined,
    out_result.hue == '0 && out_result.saturation == '0 && out_result.value == '0)

  // hue stays below 360 degrees
  `RHC_ASSERT_IMPL(a_hue_range, out_valid,
    ({1'b0, out_result.hue} < rhc_pkg::DEG360))

  // zero saturation only for grey or black, which have zero hue
  `RHC_ASSERT_IMPL(a_grey_hue, out_valid && out_result.saturation == '0,
    out_result.hue == '0)

endmodule
